// ===== src/tcfhi_pkg.sv =====
package tcfhi_pkg;

    // Chunk geometry
    localparam int CELL_SIZE_Q8   = 1067;
    localparam int CELLS_PER_SIDE = 8;
    localparam int ROW_STRIDE     = 2 * CELLS_PER_SIDE + 1;
    localparam int CENTRE_OFFSET  = CELLS_PER_SIDE + 1;
    localparam int LAT_DEPTH      = (CELLS_PER_SIDE + 1) * (CELLS_PER_SIDE + 1)
                                    + CELLS_PER_SIDE * CELLS_PER_SIDE;

    // Widths
    localparam int ADDR_W = $clog2(LAT_DEPTH);
    localparam int CELL_W = $clog2(CELLS_PER_SIDE);
    localparam int H_W    = 32;
    localparam int POS_W  = 16;
    localparam int REM_W  = $clog2(CELL_SIZE_Q8 + 1);   // holds 0..C
    localparam int WGT_W  = REM_W + 1;                  // holds 0..2C
    localparam int SUM_W  = H_W + REM_W + 1;            // signed weighted sum
    localparam int MAG_W  = H_W + REM_W;                // |sum|

    // Opcodes (tuser)
    localparam logic OP_LOAD  = 1'b0;
    localparam logic OP_QUERY = 1'b1;

    typedef enum logic [1:0] {
        TRI_NORTH,
        TRI_WEST,
        TRI_EAST,
        TRI_SOUTH
    } tri_t;

    typedef struct packed {
        logic             neg;
        logic [MAG_W-1:0] mag;
    } div_req_t;

    typedef struct packed {
        logic           neg;
        logic [H_W-1:0] quo;
    } div_resp_t;

endpackage

// ===== src/tcfhi_div.sv =====
// Divide by CELL_SIZE_Q8 as a multiply by its rounded-up reciprocal, built from
// four narrow partial products. Three stages: products, cross sum, final add.
module tcfhi_div
    import tcfhi_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      in_valid,
    output logic      in_ready,
    input  div_req_t  in_req,
    output logic      out_valid,
    input  logic      out_ready,
    output div_resp_t out_resp
);

    localparam int STAGES  = 3;
    // floor(n * RECIP / 2^REC_K) == floor(n / C) for every n below 2^MAG_W
    localparam int REC_K   = MAG_W + REM_W;
    localparam int REC_W   = MAG_W + 2;
    localparam int HALF    = (MAG_W + 1) / 2;
    localparam int NH_W    = MAG_W - HALF;
    localparam int RH_W    = REC_W - HALF;
    localparam int LL_W    = 2 * HALF;
    localparam int LH_W    = HALF + RH_W;
    localparam int HL_W    = NH_W + HALF;
    localparam int HH_W    = NH_W + RH_W;
    localparam int CROSS_W = LH_W + 1;
    localparam int PROD_W  = MAG_W + REC_W;

    localparam logic [REC_W-1:0] RECIP =
        REC_W'(((64'd1 << REC_K) + 64'(CELL_SIZE_Q8) - 64'd1) / 64'(CELL_SIZE_Q8));
    localparam logic [HALF-1:0]  REC_LO = RECIP[HALF-1:0];
    localparam logic [RH_W-1:0]  REC_HI = RECIP[REC_W-1:HALF];

    logic [STAGES-1:0]  vld_reg;
    logic [STAGES-1:0]  vld_next;
    logic [STAGES-1:0]  rdy;
    logic               neg_reg [STAGES];

    logic [HALF-1:0]    mag_lo;
    logic [NH_W-1:0]    mag_hi;
    logic [LL_W-1:0]    ll_reg;
    logic [LH_W-1:0]    lh_reg;
    logic [HL_W-1:0]    hl_reg;
    logic [HH_W-1:0]    hh_reg;
    logic [PROD_W-1:0]  outer_reg;   // {hi*hi, lo*lo}
    logic [CROSS_W-1:0] cross_reg;
    logic [PROD_W-1:0]  full_prod;
    logic [H_W-1:0]     quo_reg;

    assign mag_lo    = in_req.mag[HALF-1:0];
    assign mag_hi    = in_req.mag[MAG_W-1:HALF];
    assign full_prod = outer_reg + (PROD_W'(cross_reg) << HALF);

    always_comb
    begin
        rdy[STAGES-1] = !vld_reg[STAGES-1] || out_ready;
        for (int k = STAGES - 2; k >= 0; k--)
        begin
            rdy[k] = !vld_reg[k] || rdy[k+1];
        end
        vld_next[0] = rdy[0] ? in_valid : vld_reg[0];
        for (int k = 1; k < STAGES; k++)
        begin
            vld_next[k] = rdy[k] ? vld_reg[k-1] : vld_reg[k];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else
        begin
            vld_reg <= vld_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (rdy[0])
        begin
            ll_reg     <= LL_W'(mag_lo * REC_LO);
            lh_reg     <= LH_W'(mag_lo * REC_HI);
            hl_reg     <= HL_W'(mag_hi * REC_LO);
            hh_reg     <= HH_W'(mag_hi * REC_HI);
            neg_reg[0] <= in_req.neg;
        end
        if (rdy[1])
        begin
            outer_reg  <= {hh_reg, ll_reg};
            cross_reg  <= CROSS_W'(lh_reg) + CROSS_W'(hl_reg);
            neg_reg[1] <= neg_reg[0];
        end
        if (rdy[2])
        begin
            quo_reg    <= full_prod[REC_K +: H_W];
            neg_reg[2] <= neg_reg[1];
        end
    end

    assign in_ready  = rdy[0];
    assign out_valid = vld_reg[STAGES-1];
    assign out_resp  = '{neg: neg_reg[STAGES-1], quo: quo_reg};

endmodule

// ===== src/terrain_cell_fan_height_interp.sv =====
// Terrain chunk height lookup. The block keeps the 145 vertex heights of an
// 8x8 cell chunk (rows of 17: 9 corners, then 8 cell centres) in two mirrored
// single-write, dual-read RAMs. A beat with tuser = 0 loads one height
// (indexes above 144 are dropped, no result); a beat with tuser = 1 queries
// the height at (pos_x, pos_z), clamped to the chunk, and yields one result
// beat: the barycentric height over the cell's four-triangle centre fan,
// truncated toward zero. Loads are taken every cycle while no query is held
// and the pipeline has room. A query needs five lattice reads over four RAM
// read ports, so no beat is taken until its centre read is done. It passes
// corner read, centre read, multiply, sum, magnitude, three divide stages
// and output register. Ordering of loads and queries is exact: a query sees
// every load taken before it and none after. The output register decouples
// the sides; input keeps flowing while a result waits, until the pipeline
// fills. Contents are undefined until loaded.
module terrain_cell_fan_height_interp
    import tcfhi_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,

    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [71:0] s_axis_tdata,   // vertex_index[7:0], vertex_height[39:8],
                                        // pos_x[55:40], pos_z[71:56]
    input  logic [0:0]  s_axis_tuser,   // opcode[0]

    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [31:0] m_axis_tdata    // height[31:0]
);

    localparam int EDGE = CELLS_PER_SIDE * CELL_SIZE_Q8;

    // ---------------- helpers ----------------
    function automatic logic [POS_W-1:0] clamp_axis(logic signed [POS_W-1:0] p);
        logic [POS_W-1:0] r;
        if (p[POS_W-1])
        begin
            r = '0;
        end
        else if (int'(p) > EDGE)
        begin
            r = POS_W'(EDGE);
        end
        else
        begin
            r = $unsigned(p);
        end
        return r;
    endfunction

    // cell index = min(p / C, 7), by parallel compares against k*C
    function automatic logic [CELL_W-1:0] cell_of(logic [POS_W-1:0] p);
        logic [CELL_W-1:0] c;
        c = '0;
        for (int k = 1; k < CELLS_PER_SIDE; k++)
        begin
            if (int'(p) >= k * CELL_SIZE_Q8)
            begin
                c = CELL_W'(k);
            end
        end
        return c;
    endfunction

    // ---------------- input decode ----------------
    logic                    opcode;
    logic [ADDR_W-1:0]       vertex_index;
    logic signed [H_W-1:0]   vertex_height;
    logic signed [POS_W-1:0] pos_x;
    logic signed [POS_W-1:0] pos_z;

    assign opcode        = s_axis_tuser[0];
    assign vertex_index  = s_axis_tdata[7:0];
    assign vertex_height = s_axis_tdata[39:8];
    assign pos_x         = s_axis_tdata[55:40];
    assign pos_z         = s_axis_tdata[71:56];

    logic s_acc, acc_load, acc_query, wr_en;

    assign s_acc     = s_axis_tvalid && s_axis_tready;
    assign acc_load  = s_acc && (opcode == OP_LOAD);
    assign acc_query = s_acc && (opcode == OP_QUERY);
    assign wr_en     = acc_load && (int'(vertex_index) < LAT_DEPTH);

    logic [POS_W-1:0]  px, pz;
    logic [CELL_W-1:0] col, row;
    logic [REM_W-1:0]  ru, rv;
    logic [ADDR_W-1:0] base, a00, a10, a01, a11;

    always_comb
    begin
        px   = clamp_axis(pos_x);
        pz   = clamp_axis(pos_z);
        col  = cell_of(px);
        row  = cell_of(pz);
        ru   = REM_W'(px - POS_W'(CELL_SIZE_Q8 * int'(col)));
        rv   = REM_W'(pz - POS_W'(CELL_SIZE_Q8 * int'(row)));
        base = ADDR_W'(int'(row) * ROW_STRIDE + int'(col));
        a00  = base;
        a10  = base + ADDR_W'(1);
        a01  = base + ADDR_W'(ROW_STRIDE);
        a11  = base + ADDR_W'(ROW_STRIDE + 1);
    end

    // ---------------- pipeline control ----------------
    logic v0_reg, v1_reg, v2_reg, v3_reg, v4_reg;
    logic v0_next, v1_next, v2_next, v3_next, v4_next;
    logic rdy1, rdy2, rdy3, rdy4;
    logic move01;
    logic div_in_ready, div_out_valid, out_rdy;
    logic m_valid_reg, m_valid_next;

    always_comb
    begin
        out_rdy       = !m_valid_reg || m_axis_tready;
        rdy4          = !v4_reg || div_in_ready;
        rdy3          = !v3_reg || rdy4;
        rdy2          = !v2_reg || rdy3;
        rdy1          = !v1_reg || rdy2;
        // a held query owns port A0 until its centre read is done
        s_axis_tready = !v0_reg && rdy1;
        move01        = v0_reg && rdy1;

        v0_next      = acc_query || (v0_reg && !rdy1);
        v1_next      = rdy1 ? v0_reg : v1_reg;
        v2_next      = rdy2 ? v1_reg : v2_reg;
        v3_next      = rdy3 ? v2_reg : v3_reg;
        v4_next      = rdy4 ? v3_reg : v4_reg;
        m_valid_next = out_rdy ? div_out_valid : m_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v0_reg      <= 1'b0;
            v1_reg      <= 1'b0;
            v2_reg      <= 1'b0;
            v3_reg      <= 1'b0;
            v4_reg      <= 1'b0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            v0_reg      <= v0_next;
            v1_reg      <= v1_next;
            v2_reg      <= v2_next;
            v3_reg      <= v3_next;
            v4_reg      <= v4_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // ---------------- lattice store ----------------
    // Two mirrored copies: four read ports. Corners are read on the query
    // beat, the centre through port A0 when the held query moves to stage 1.
    logic signed [H_W-1:0] mem_a [LAT_DEPTH];
    logic signed [H_W-1:0] mem_b [LAT_DEPTH];
    logic signed [H_W-1:0] rd_a0_reg, rd_a1_reg, rd_b0_reg, rd_b1_reg;
    logic [ADDR_W-1:0]     hc_addr;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem_a[vertex_index] <= vertex_height;
            mem_b[vertex_index] <= vertex_height;
        end
        if (acc_query)
        begin
            rd_a0_reg <= mem_a[a00];
            rd_a1_reg <= mem_a[a10];
            rd_b0_reg <= mem_b[a01];
            rd_b1_reg <= mem_b[a11];
        end
        else if (move01)
        begin
            rd_a0_reg <= mem_a[hc_addr];
        end
    end

    // ---------------- stage 0: query context ----------------
    logic [REM_W-1:0]  ru_reg, rv_reg;
    logic [ADDR_W-1:0] base_reg;

    assign hc_addr = base_reg + ADDR_W'(CENTRE_OFFSET);

    always_ff @(posedge clk)
    begin
        if (acc_query)
        begin
            ru_reg   <= ru;
            rv_reg   <= rv;
            base_reg <= base;
        end
    end

    // ---------------- stage 1: triangle pick, weights ----------------
    tri_t                  tri_sel;
    logic [WGT_W-1:0]      wa, wb, wc;
    logic signed [H_W-1:0] ha, hb;

    always_comb
    begin
        int ru_i, rv_i;
        ru_i = int'(ru_reg);
        rv_i = int'(rv_reg);
        if (ru_i + rv_i < CELL_SIZE_Q8)
        begin
            tri_sel = (rv_i < ru_i) ? TRI_NORTH : TRI_WEST;
        end
        else
        begin
            tri_sel = (rv_i < ru_i) ? TRI_EAST : TRI_SOUTH;
        end
        case (tri_sel)
            TRI_NORTH:
            begin
                wa = WGT_W'(CELL_SIZE_Q8 - ru_i - rv_i);
                wb = WGT_W'(ru_i - rv_i);
                wc = WGT_W'(2 * rv_i);
                ha = rd_a0_reg;
                hb = rd_a1_reg;
            end
            TRI_WEST:
            begin
                wa = WGT_W'(CELL_SIZE_Q8 - ru_i - rv_i);
                wb = WGT_W'(rv_i - ru_i);
                wc = WGT_W'(2 * ru_i);
                ha = rd_a0_reg;
                hb = rd_b0_reg;
            end
            TRI_EAST:
            begin
                wa = WGT_W'(ru_i - rv_i);
                wb = WGT_W'(ru_i + rv_i - CELL_SIZE_Q8);
                wc = WGT_W'(2 * (CELL_SIZE_Q8 - ru_i));
                ha = rd_a1_reg;
                hb = rd_b1_reg;
            end
            TRI_SOUTH:
            begin
                wa = WGT_W'(rv_i - ru_i);
                wb = WGT_W'(ru_i + rv_i - CELL_SIZE_Q8);
                wc = WGT_W'(2 * (CELL_SIZE_Q8 - rv_i));
                ha = rd_b0_reg;
                hb = rd_b1_reg;
            end
            default:
            begin
                wa = '0;
                wb = '0;
                wc = '0;
                ha = '0;
                hb = '0;
            end
        endcase
    end

    logic [WGT_W-1:0]      wa_reg, wb_reg, wc_reg;
    logic signed [H_W-1:0] ha_reg, hb_reg;

    always_ff @(posedge clk)
    begin
        if (move01)
        begin
            wa_reg <= wa;
            wb_reg <= wb;
            wc_reg <= wc;
            ha_reg <= ha;
            hb_reg <= hb;
        end
    end

    // ---------------- stage 2: products (centre height in rd_a0_reg) ----------------
    logic signed [SUM_W-1:0] pa_reg, pb_reg, pc_reg;

    always_ff @(posedge clk)
    begin
        if (rdy2)
        begin
            pa_reg <= SUM_W'($signed(ha_reg) * $signed({1'b0, wa_reg}));
            pb_reg <= SUM_W'($signed(hb_reg) * $signed({1'b0, wb_reg}));
            pc_reg <= SUM_W'($signed(rd_a0_reg) * $signed({1'b0, wc_reg}));
        end
    end

    // ---------------- stage 3: weighted sum ----------------
    logic signed [SUM_W-1:0] sum_reg;

    always_ff @(posedge clk)
    begin
        if (rdy3)
        begin
            sum_reg <= pa_reg + pb_reg + pc_reg;
        end
    end

    // ---------------- stage 4: sign / magnitude ----------------
    div_req_t         req_reg;
    logic [SUM_W-1:0] sum_abs;

    assign sum_abs = sum_reg[SUM_W-1] ? $unsigned(-sum_reg) : $unsigned(sum_reg);

    always_ff @(posedge clk)
    begin
        if (rdy4)
        begin
            req_reg.neg <= sum_reg[SUM_W-1];
            req_reg.mag <= sum_abs[MAG_W-1:0];
        end
    end

    // ---------------- divide by cell size ----------------
    div_resp_t div_resp;

    tcfhi_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (v4_reg),
        .in_ready  (div_in_ready),
        .in_req    (req_reg),
        .out_valid (div_out_valid),
        .out_ready (out_rdy),
        .out_resp  (div_resp)
    );

    // ---------------- output register ----------------
    logic [H_W-1:0] height_reg;

    always_ff @(posedge clk)
    begin
        if (out_rdy && div_out_valid)
        begin
            height_reg <= div_resp.neg ? (~div_resp.quo + H_W'(1)) : div_resp.quo;
        end
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = height_reg;

    // ---------------- assertions ----------------
    // centre read occupies a RAM port: no beat may follow a query directly
    a_query_gap: assert property (@(posedge clk) disable iff (!rst_n)
        acc_query |=> !s_axis_tready)
        else $error("beat taken while centre read pending");

    a_base_range: assert property (@(posedge clk) disable iff (!rst_n)
        v0_reg |-> (int'(base_reg) + ROW_STRIDE + 1 < LAT_DEPTH))
        else $error("cell base outside lattice");

    // barycentric weights of every fan triangle add up to one cell
    a_weight_sum: assert property (@(posedge clk) disable iff (!rst_n)
        v1_reg |-> (int'(wa_reg) + int'(wb_reg) + int'(wc_reg) == CELL_SIZE_Q8))
        else $error("weights do not sum to cell size");

endmodule
